// ----- rtl/rcci_pkg.sv -----
// Shared types and constants for the capped cylinder ray test.
`timescale 1ns / 1ps

package rcci_pkg;

  // Configuration register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_X     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_Y     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_Z     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CYL_HEIGHT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CYL_RADIUS = 3'd4;

  // Reset values of height and radius (1.0 in Q16.16)
  localparam logic [30:0] HEIGHT_RST = 31'd65536;
  localparam logic [30:0] RADIUS_RST = 31'd65536;

  // Surface part codes
  localparam logic [1:0] PART_SIDE   = 2'd0;
  localparam logic [1:0] PART_TOP    = 2'd1;
  localparam logic [1:0] PART_BOTTOM = 2'd2;
  localparam logic [1:0] PART_RSVD   = 2'd3;

  // Datapath widths
  localparam int MAG_W  = 65;   // magnitude of a root numerator
  localparam int DEN_W  = 64;   // divisor width
  localparam int Q_W    = 32;   // quotient width
  localparam int ROOT_W = 64;   // square root width
  localparam int LANES  = 4;

  // Divider lane allocation
  localparam int LANE_TMIN = 0;
  localparam int LANE_TMAX = 1;
  localparam int LANE_YMIN = 2;
  localparam int LANE_YMAX = 3;

  // Per-ray fields carried alongside the square root
  typedef struct packed {
    logic               miss;
    logic               bneg;
    logic [63:0]        bm;
    logic [63:0]        a;
    logic signed [33:0] ny_min;
    logic signed [33:0] ny_max;
    logic signed [31:0] dy;
    logic               in_slab;
  } side_t;

  // Per-ray flags carried alongside the divider
  typedef struct packed {
    logic miss;
    logic dy_zero;
    logic dy_neg;
    logic in_slab;
  } tail_t;

endpackage

// ----- rtl/rcci_front.sv -----
// Front end: products, quadratic coefficients and side discriminant.
`timescale 1ns / 1ps

module rcci_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic signed [31:0] origin_x,
  input  logic signed [31:0] origin_y,
  input  logic signed [31:0] origin_z,
  input  logic signed [31:0] dir_x,
  input  logic signed [31:0] dir_y,
  input  logic signed [31:0] dir_z,
  input  logic signed [31:0] base_x,
  input  logic signed [31:0] base_y,
  input  logic signed [31:0] base_z,
  input  logic [30:0]        cyl_height,
  input  logic [30:0]        cyl_radius,
  output logic               out_valid,
  output logic [127:0]       disc,
  output rcci_pkg::side_t    side
);
  import rcci_pkg::*;

  // Stage 1: offsets from the base and plane distances in y
  logic               v1_r;
  logic signed [32:0] px1_r, pz1_r, px1_nxt, pz1_nxt;
  logic signed [31:0] dx1_r, dz1_r, dy1_r;
  logic signed [33:0] nlo1_r, nhi1_r, nlo1_nxt, nhi1_nxt, ty;
  logic [30:0]        r1_r;

  always_comb begin
    px1_nxt  = 33'(origin_x) - 33'(base_x);
    pz1_nxt  = 33'(origin_z) - 33'(base_z);
    ty       = 34'(base_y) + 34'(signed'({1'b0, cyl_height}));
    nlo1_nxt = 34'(base_y) - 34'(origin_y);
    nhi1_nxt = ty - 34'(origin_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en) v1_r <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px1_r  <= px1_nxt;
      pz1_r  <= pz1_nxt;
      dx1_r  <= dir_x;
      dz1_r  <= dir_z;
      dy1_r  <= dir_y;
      nlo1_r <= nlo1_nxt;
      nhi1_r <= nhi1_nxt;
      r1_r   <= cyl_radius;
    end
  end

  // Stage 2: cross products, squares and slab order
  logic               v2_r, in2_r;
  logic signed [64:0] p1_r, p2_r, p3_r, p4_r;
  logic [63:0]        dxx2_r, dzz2_r;
  logic [61:0]        rr2_r;
  logic signed [31:0] dy2_r;
  logic signed [33:0] nmin2_r, nmax2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en) v2_r <= v1_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p1_r    <= 65'(px1_r) * 65'(dx1_r);
      p2_r    <= 65'(pz1_r) * 65'(dx1_r);
      p3_r    <= 65'(px1_r) * 65'(dz1_r);
      p4_r    <= 65'(pz1_r) * 65'(dz1_r);
      dxx2_r  <= $unsigned(64'(dx1_r) * 64'(dx1_r));
      dzz2_r  <= $unsigned(64'(dz1_r) * 64'(dz1_r));
      rr2_r   <= 62'(r1_r) * 62'(r1_r);
      dy2_r   <= dy1_r;
      nmin2_r <= dy1_r[31] ? nhi1_r : nlo1_r;
      nmax2_r <= dy1_r[31] ? nlo1_r : nhi1_r;
      in2_r   <= (nlo1_r <= 34'sd0) && (nhi1_r >= 34'sd0);
    end
  end

  // Stage 3: a, b and c in sign and magnitude
  logic               v3_r;
  side_t              side3_r, side3_nxt;
  logic [63:0]        cm3_r, cm3_nxt;
  logic [61:0]        rr3_r;
  logic signed [65:0] b_sum, c_sum, b_abs, c_abs;
  logic [63:0]        a_sum;

  always_comb begin
    a_sum = dxx2_r + dzz2_r;
    b_sum = 66'(p1_r) + 66'(p4_r);
    c_sum = 66'(p3_r) - 66'(p2_r);
    b_abs = b_sum[65] ? -b_sum : b_sum;
    c_abs = c_sum[65] ? -c_sum : c_sum;
    side3_nxt.miss    = (a_sum == 64'd0);
    side3_nxt.bneg    = b_sum[65];
    side3_nxt.bm      = b_abs[63:0];
    side3_nxt.a       = a_sum;
    side3_nxt.ny_min  = nmin2_r;
    side3_nxt.ny_max  = nmax2_r;
    side3_nxt.dy      = dy2_r;
    side3_nxt.in_slab = in2_r;
    cm3_nxt           = c_abs[63:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en) v3_r <= v2_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side3_r <= side3_nxt;
      cm3_r   <= cm3_nxt;
      rr3_r   <= rr2_r;
    end
  end

  // Stage 4: 32 by 32 partial products of a*r^2 and c^2
  logic        v4_r;
  side_t       side4_r;
  logic [63:0] a_ll_r, a_lh_r, a_hl_r, a_hh_r;
  logic [63:0] c_ll_r, c_lh_r, c_hh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en) v4_r <= v3_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side4_r <= side3_r;
      a_ll_r  <= 64'(side3_r.a[31:0])  * 64'(rr3_r[31:0]);
      a_lh_r  <= 64'(side3_r.a[31:0])  * 64'(rr3_r[61:32]);
      a_hl_r  <= 64'(side3_r.a[63:32]) * 64'(rr3_r[31:0]);
      a_hh_r  <= 64'(side3_r.a[63:32]) * 64'(rr3_r[61:32]);
      c_ll_r  <= 64'(cm3_r[31:0])  * 64'(cm3_r[31:0]);
      c_lh_r  <= 64'(cm3_r[31:0])  * 64'(cm3_r[63:32]);
      c_hh_r  <= 64'(cm3_r[63:32]) * 64'(cm3_r[63:32]);
    end
  end

  // Stage 5: sum the partial products
  logic         v5_r;
  side_t        side5_r;
  logic [127:0] ar2_r, cr2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) v5_r <= 1'b0;
    else if (en) v5_r <= v4_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side5_r <= side4_r;
      ar2_r   <= 128'(a_ll_r) + (128'(a_lh_r) << 32) + (128'(a_hl_r) << 32)
               + (128'(a_hh_r) << 64);
      cr2_r   <= 128'(c_ll_r) + (128'(c_lh_r) << 33) + (128'(c_hh_r) << 64);
    end
  end

  // Stage 6: reject a negative discriminant, form a*r^2 - c^2
  logic         v6_r;
  side_t        side6_r, side6_nxt;
  logic [127:0] disc6_r;

  always_comb begin
    side6_nxt      = side5_r;
    side6_nxt.miss = side5_r.miss | (cr2_r > ar2_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) v6_r <= 1'b0;
    else if (en) v6_r <= v5_r;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side6_r <= side6_nxt;
      disc6_r <= ar2_r - cr2_r;
    end
  end

  assign out_valid = v6_r;
  assign disc      = disc6_r;
  assign side      = side6_r;

endmodule

// ----- rtl/rcci_sqrt.sv -----
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps

module rcci_sqrt #(
  parameter int SB_W = 1
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         en,
  input  logic                         in_valid,
  input  logic [2*rcci_pkg::ROOT_W-1:0] radicand,
  input  logic [SB_W-1:0]              in_sb,
  output logic                         out_valid,
  output logic [rcci_pkg::ROOT_W-1:0]  root,
  output logic [SB_W-1:0]              out_sb
);
  import rcci_pkg::*;

  localparam int XW = 2 * ROOT_W;

  logic [XW-1:0]     x_r  [ROOT_W];
  logic [ROOT_W-1:0] r_r  [ROOT_W];
  logic [SB_W-1:0]   sb_r [ROOT_W];
  logic              v_r  [ROOT_W];

  // Stage k decides root bit k from the remainder v - r^2
  for (genvar k = 0; k < ROOT_W; k++) begin : g_bit
    logic [XW-1:0]     x_p;
    logic [ROOT_W-1:0] r_p;
    logic [SB_W-1:0]   sb_p;
    logic              v_p;
    logic [XW:0]       term;
    logic              take;

    if (k == ROOT_W - 1) begin : g_first
      assign x_p  = radicand;
      assign r_p  = '0;
      assign sb_p = in_sb;
      assign v_p  = in_valid;
    end else begin : g_next
      assign x_p  = x_r[k+1];
      assign r_p  = r_r[k+1];
      assign sb_p = sb_r[k+1];
      assign v_p  = v_r[k+1];
    end

    // (r + 2^k)^2 - r^2 = 2^(k+1) r + 2^(2k)
    assign term = ((XW+1)'(r_p) << (k + 1)) + ((XW+1)'(1) << (2 * k));
    assign take = {1'b0, x_p} >= term;

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else if (en) v_r[k] <= v_p;
    end

    always_ff @(posedge clk) begin
      if (en) begin
        x_r[k]  <= take ? x_p - term[XW-1:0] : x_p;
        r_r[k]  <= take ? (r_p | (ROOT_W'(1) << k)) : r_p;
        sb_r[k] <= sb_p;
      end
    end
  end

  assign out_valid = v_r[0];
  assign root      = r_r[0];
  assign out_sb    = sb_r[0];

endmodule

// ----- rtl/rcci_div.sv -----
// Pipelined restoring divider lanes with saturation to 32 bits.
`timescale 1ns / 1ps

module rcci_div #(
  parameter int FRAC_BITS = 16,
  parameter int SB_W      = 1
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   en,
  input  logic                                   in_valid,
  input  logic [rcci_pkg::MAG_W+FRAC_BITS-1:0]   num [rcci_pkg::LANES],
  input  logic [rcci_pkg::DEN_W-1:0]             den [rcci_pkg::LANES],
  input  logic                                   neg [rcci_pkg::LANES],
  input  logic [SB_W-1:0]                        in_sb,
  output logic                                   out_valid,
  output logic signed [rcci_pkg::Q_W-1:0]        quo [rcci_pkg::LANES],
  output logic [SB_W-1:0]                        out_sb
);
  import rcci_pkg::*;

  localparam int NW = MAG_W + FRAC_BITS;
  localparam int RW = DEN_W + 1;

  logic [RW-1:0]    rem_r [Q_W+1][LANES];
  logic [Q_W-1:0]   lo_r  [Q_W+1][LANES];
  logic [Q_W-1:0]   q_r   [Q_W+1][LANES];
  logic [DEN_W-1:0] den_r [Q_W+1][LANES];
  logic             neg_r [Q_W+1][LANES];
  logic             ovf_r [Q_W+1][LANES];
  logic [SB_W-1:0]  sb_r  [Q_W+1];
  logic             v_r   [Q_W+1];

  // Capture: flag quotients of 2^32 or more, seed the remainder
  always_ff @(posedge clk) begin
    if (!rst_n) v_r[Q_W] <= 1'b0;
    else if (en) v_r[Q_W] <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (en) sb_r[Q_W] <= in_sb;
  end

  for (genvar l = 0; l < LANES; l++) begin : g_cap
    always_ff @(posedge clk) begin
      if (en) begin
        ovf_r[Q_W][l] <= RW'(num[l][NW-1:Q_W]) >= RW'(den[l]);
        rem_r[Q_W][l] <= RW'(num[l][NW-1:Q_W]);
        lo_r[Q_W][l]  <= num[l][Q_W-1:0];
        q_r[Q_W][l]   <= '0;
        den_r[Q_W][l] <= den[l];
        neg_r[Q_W][l] <= neg[l];
      end
    end
  end

  // Step k: shift in numerator bit k, subtract where it fits
  for (genvar k = 0; k < Q_W; k++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k] <= 1'b0;
      else if (en) v_r[k] <= v_r[k+1];
    end

    always_ff @(posedge clk) begin
      if (en) sb_r[k] <= sb_r[k+1];
    end

    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic [RW-1:0] rem2;
      logic          ge;

      assign rem2 = {rem_r[k+1][l][RW-2:0], lo_r[k+1][l][k]};
      assign ge   = rem2 >= {1'b0, den_r[k+1][l]};

      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k][l] <= ge ? rem2 - {1'b0, den_r[k+1][l]} : rem2;
          q_r[k][l]   <= q_r[k+1][l] | (Q_W'(ge) << k);
          lo_r[k][l]  <= lo_r[k+1][l];
          den_r[k][l] <= den_r[k+1][l];
          neg_r[k][l] <= neg_r[k+1][l];
          ovf_r[k][l] <= ovf_r[k+1][l];
        end
      end
    end
  end

  // Output: apply sign, saturate to the signed 32-bit range
  logic                  vo_r;
  logic [SB_W-1:0]       sbo_r;
  logic signed [Q_W-1:0] res_r [LANES];

  always_ff @(posedge clk) begin
    if (!rst_n) vo_r <= 1'b0;
    else if (en) vo_r <= v_r[0];
  end

  always_ff @(posedge clk) begin
    if (en) sbo_r <= sb_r[0];
  end

  for (genvar l = 0; l < LANES; l++) begin : g_sat
    logic [Q_W-1:0] lim;
    logic           sat;

    // Limit is 2^31 for negative results and 2^31-1 otherwise
    assign lim = {neg_r[0][l], {(Q_W-1){~neg_r[0][l]}}};
    assign sat = ovf_r[0][l] || (q_r[0][l] > lim);

    always_ff @(posedge clk) begin
      if (en) begin
        res_r[l] <= sat ? signed'(lim)
                  : (neg_r[0][l] ? -signed'(q_r[0][l]) : signed'(q_r[0][l]));
      end
    end
    assign quo[l] = res_r[l];
  end

  assign out_valid = vo_r;
  assign out_sb    = sbo_r;

endmodule

// ----- rtl/ray_capped_cylinder_intersect.sv -----
// Top level: ray against upright capped cylinder, fully pipelined.
// Use: rays enter on the in_ channel (origin and direction, signed Q16.16)
// and one result per ray leaves on the out_ channel: hit, entry distance
// t_hit and the part entered (side, top cap, bottom cap); a miss reads zero.
// Both channels move a request on a rising edge with valid high and stall low.
// Cylinder position, height and radius are written through the cfg_ port,
// which is always ready; write it only while no request is in flight.
// Throughput is one ray per cycle unless out_stall holds the pipeline. Stages:
// six front stages, 64 square root stages (one root bit each), one numerator
// stage, 34 divider stages (one quotient bit each plus capture and
// saturation) and the output register.
// The whole pipeline advances together; while the output register holds a
// result that the receiver stalls, every stage holds and in_stall is raised,
// so nothing is dropped or repeated. A free output register keeps the input
// open even while results are in flight.
// Reset clears all valid bits and loads base 0, height 1.0 and radius 1.0.
`timescale 1ns / 1ps

module ray_capped_cylinder_intersect #(
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [31:0]                in_origin_x,
  input  logic signed [31:0]                in_origin_y,
  input  logic signed [31:0]                in_origin_z,
  input  logic signed [31:0]                in_dir_x,
  input  logic signed [31:0]                in_dir_y,
  input  logic signed [31:0]                in_dir_z,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_hit,
  output logic signed [31:0]                out_t_hit,
  output logic [1:0]                        out_hit_part,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [rcci_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [31:0]                       cfg_data
);
  import rcci_pkg::*;

  localparam int NUM_W = MAG_W + FRAC_BITS;

  logic               out_valid_r, out_hit_r;
  logic signed [31:0] out_t_hit_r;
  logic [1:0]         out_hit_part_r;
  logic               en;

  // Advance whenever the output register is free or being taken
  assign en       = !out_valid_r || !out_stall;
  assign in_stall = !en;

  // Configuration registers
  logic signed [31:0] base_x_r, base_y_r, base_z_r;
  logic [30:0]        cyl_height_r, cyl_radius_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_x_r     <= '0;
      base_y_r     <= '0;
      base_z_r     <= '0;
      cyl_height_r <= HEIGHT_RST;
      cyl_radius_r <= RADIUS_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_BASE_X:     base_x_r     <= cfg_data;
        REG_BASE_Y:     base_y_r     <= cfg_data;
        REG_BASE_Z:     base_z_r     <= cfg_data;
        REG_CYL_HEIGHT: cyl_height_r <= cfg_data[30:0];
        REG_CYL_RADIUS: cyl_radius_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // Front end
  logic         fr_valid;
  logic [127:0] fr_disc;
  side_t        fr_side;

  rcci_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .in_valid   (in_valid),
    .origin_x   (in_origin_x),
    .origin_y   (in_origin_y),
    .origin_z   (in_origin_z),
    .dir_x      (in_dir_x),
    .dir_y      (in_dir_y),
    .dir_z      (in_dir_z),
    .base_x     (base_x_r),
    .base_y     (base_y_r),
    .base_z     (base_z_r),
    .cyl_height (cyl_height_r),
    .cyl_radius (cyl_radius_r),
    .out_valid  (fr_valid),
    .disc       (fr_disc),
    .side       (fr_side)
  );

  // Square root of the quarter discriminant
  logic                  sq_valid;
  logic [ROOT_W-1:0]     sq_root;
  logic [$bits(side_t)-1:0] sq_sb;

  rcci_sqrt #(
    .SB_W ($bits(side_t))
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .radicand  (fr_disc),
    .in_sb     (fr_side),
    .out_valid (sq_valid),
    .root      (sq_root),
    .out_sb    (sq_sb)
  );

  // Numerator stage: roots -b -/+ s and plane distances, sign and magnitude
  side_t              sd;
  logic signed [66:0] nb, s67, nmin, nmax, amin, amax;
  logic signed [33:0] ymin_abs, ymax_abs;
  logic signed [31:0] dy_abs;
  logic               dyneg;

  logic [NUM_W-1:0] num_nxt [LANES];
  logic [DEN_W-1:0] den_nxt [LANES];
  logic             neg_nxt [LANES];
  tail_t            tail_nxt;

  always_comb begin
    sd       = side_t'(sq_sb);
    dyneg    = sd.dy[31];
    nb       = sd.bneg ? signed'(67'(sd.bm)) : -signed'(67'(sd.bm));
    s67      = signed'(67'(sq_root));
    nmin     = nb - s67;
    nmax     = nb + s67;
    amin     = nmin[66] ? -nmin : nmin;
    amax     = nmax[66] ? -nmax : nmax;
    ymin_abs = sd.ny_min[33] ? -sd.ny_min : sd.ny_min;
    ymax_abs = sd.ny_max[33] ? -sd.ny_max : sd.ny_max;
    dy_abs   = dyneg ? -sd.dy : sd.dy;

    num_nxt[LANE_TMIN] = {amin[MAG_W-1:0], {FRAC_BITS{1'b0}}};
    den_nxt[LANE_TMIN] = sd.a;
    neg_nxt[LANE_TMIN] = nmin[66];
    num_nxt[LANE_TMAX] = {amax[MAG_W-1:0], {FRAC_BITS{1'b0}}};
    den_nxt[LANE_TMAX] = sd.a;
    neg_nxt[LANE_TMAX] = nmax[66];
    num_nxt[LANE_YMIN] = NUM_W'({ymin_abs[33:0], {FRAC_BITS{1'b0}}});
    den_nxt[LANE_YMIN] = DEN_W'($unsigned(dy_abs));
    neg_nxt[LANE_YMIN] = sd.ny_min[33] ^ dyneg;
    num_nxt[LANE_YMAX] = NUM_W'({ymax_abs[33:0], {FRAC_BITS{1'b0}}});
    den_nxt[LANE_YMAX] = DEN_W'($unsigned(dy_abs));
    neg_nxt[LANE_YMAX] = sd.ny_max[33] ^ dyneg;

    tail_nxt.miss    = sd.miss;
    tail_nxt.dy_zero = (sd.dy == 32'sd0);
    tail_nxt.dy_neg  = dyneg;
    tail_nxt.in_slab = sd.in_slab;
  end

  logic             pv_r;
  logic [NUM_W-1:0] pnum_r [LANES];
  logic [DEN_W-1:0] pden_r [LANES];
  logic             pneg_r [LANES];
  tail_t            ptail_r;

  always_ff @(posedge clk) begin
    if (!rst_n) pv_r <= 1'b0;
    else if (en) pv_r <= sq_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pnum_r  <= num_nxt;
      pden_r  <= den_nxt;
      pneg_r  <= neg_nxt;
      ptail_r <= tail_nxt;
    end
  end

  // Four quotients: side roots and cap plane distances
  logic                  dv_valid;
  logic signed [Q_W-1:0] dv_quo [LANES];
  logic [$bits(tail_t)-1:0] dv_sb;

  rcci_div #(
    .FRAC_BITS (FRAC_BITS),
    .SB_W      ($bits(tail_t))
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (pv_r),
    .num       (pnum_r),
    .den       (pden_r),
    .neg       (pneg_r),
    .in_sb     (ptail_r),
    .out_valid (dv_valid),
    .quo       (dv_quo),
    .out_sb    (dv_sb)
  );

  // Clip the side interval by the cap slab
  tail_t                 tl;
  logic signed [Q_W-1:0] tmin, tmax, ymin, ymax, t_sel;
  logic [1:0]            part_sel;
  logic                  hit_nxt;
  logic signed [31:0]    t_nxt;
  logic [1:0]            part_nxt;

  always_comb begin
    tl      = tail_t'(dv_sb);
    tmin    = dv_quo[LANE_TMIN];
    tmax    = dv_quo[LANE_TMAX];
    ymin    = dv_quo[LANE_YMIN];
    ymax    = dv_quo[LANE_YMAX];
    t_sel    = tmin;
    part_sel = PART_SIDE;
    if (ymin > tmin) begin
      t_sel    = ymin;
      part_sel = tl.dy_neg ? PART_TOP : PART_BOTTOM;
    end
    hit_nxt  = 1'b0;
    t_nxt    = '0;
    part_nxt = PART_SIDE;
    if (!tl.miss) begin
      if (tl.dy_zero) begin
        if (tl.in_slab) begin
          hit_nxt = 1'b1;
          t_nxt   = tmin;
        end
      end else if (!(ymin > tmax) && !(ymax < t_sel)) begin
        hit_nxt  = 1'b1;
        t_nxt    = t_sel;
        part_nxt = part_sel;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (en) out_valid_r <= dv_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r      <= hit_nxt;
      out_t_hit_r    <= t_nxt;
      out_hit_part_r <= part_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_hit      = out_hit_r;
  assign out_t_hit    = out_t_hit_r;
  assign out_hit_part = out_hit_part_r;

  // Checks
  a_open_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid_r |-> !in_stall)
    else $error("input stalled with an empty output register");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_hit_r |-> out_t_hit_r == 32'sd0 && out_hit_part_r == PART_SIDE)
    else $error("miss with non-zero fields");

  a_part_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_hit_part_r != PART_RSVD)
    else $error("reserved surface part code");

endmodule
